// ===== hdl/b64enc_pkg.sv =====
// ----------------------------------------------------------------------------
// b64enc_pkg
// Types, constants and the alphabet lookup for the streaming base64 encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package b64enc_pkg;

    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int unsigned QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] NVALID_ONE   = 2'd1;
    localparam logic [1:0] NVALID_TWO   = 2'd2;
    localparam logic [1:0] NVALID_THREE = 2'd3;

    localparam logic [1:0] CHAR_IDX_LAST = 2'd3;

    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
    localparam logic [7:0] CHAR_PLUS    = 8'h2B;
    localparam logic [7:0] CHAR_SLASH   = 8'h2F;
    localparam logic [7:0] CHAR_PAD     = 8'h3D;

    localparam logic [5:0] SIX_LOWER_BASE = 6'd26;
    localparam logic [5:0] SIX_DIGIT_BASE = 6'd52;
    localparam logic [5:0] SIX_PLUS       = 6'd62;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_message;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] out_char;
        logic       group_last;
        logic       message_done;
    } t_out_beat;

    typedef struct packed {
        logic [7:0] byte_a;
        logic [7:0] byte_b;
        logic [7:0] byte_c;
        logic [1:0] nvalid;
        logic       done;
    } t_group;

    typedef struct packed {
        logic                full;
        logic                not_empty;
        logic [QUEUE_CW-1:0] count;
    } t_q_status;

    function automatic logic [7:0] b64_char(input logic [5:0] six);
        logic [7:0] ch;
        priority if (six < SIX_LOWER_BASE) begin
            ch = CHAR_UPPER_A + {2'b00, six};
        end else if (six < SIX_DIGIT_BASE) begin
            ch = CHAR_LOWER_A + {2'b00, six - SIX_LOWER_BASE};
        end else if (six < SIX_PLUS) begin
            ch = CHAR_DIGIT_0 + {2'b00, six - SIX_DIGIT_BASE};
        end else if (six == SIX_PLUS) begin
            ch = CHAR_PLUS;
        end else begin
            ch = CHAR_SLASH;
        end
        return ch;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/base64_stream_encoder_core.sv =====
// The first character of a group is valid on the output once the group has passed through
// the queue, the group register and the output register after its last byte is taken.
// The output register gives one character per cycle while i_out_ready is high and groups
// are available; a full group of three bytes and a short, padded final group both give four characters.
// The input side takes one byte per cycle while the two-group queue has room.
// Reset (i_rst_n low, synchronous) empties the queue and drops held bytes.
// ----------------------------------------------------------------------------
// base64_stream_encoder_core
// Streaming base64 encoder with padding: byte beats in, character beats out.
// ----------------------------------------------------------------------------
`default_nettype none

module base64_stream_encoder_core
    import b64enc_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  wire t_in_beat i_in_data,
    output logic          o_out_valid,
    input  wire logic     i_out_ready,
    output t_out_beat     o_out_data
);

    t_q_status s_q_status;
    logic      s_push;
    t_group    s_push_data;
    logic      s_pop;
    t_group    s_pop_data;

    b64enc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .i_q_status  (s_q_status),
        .o_push      (s_push),
        .o_push_data (s_push_data)
    );

    b64enc_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (s_push),
        .i_push_data (s_push_data),
        .i_pop       (s_pop),
        .o_pop_data  (s_pop_data),
        .o_status    (s_q_status)
    );

    b64enc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_status  (s_q_status),
        .i_q_data    (s_pop_data),
        .o_pop       (s_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

`ifndef NO_ASSERTIONS
    a_q_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_q_status.count <= QUEUE_CW'(QUEUE_DEPTH))
        else $error("group queue count out of range");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_push && s_q_status.full))
        else $error("group pushed into full queue");

    a_done_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.message_done) |-> o_out_data.group_last)
        else $error("message end not on last character of a group");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_pop && !s_q_status.not_empty) |=> !o_out_valid || $past(o_out_valid))
        else $error("character beat without a group");
`endif

endmodule

`default_nettype wire

// ===== hdl/b64enc_front.sv =====
// ----------------------------------------------------------------------------
// b64enc_front
// Accepts message bytes, holds up to two, and pushes complete or final groups.
// ----------------------------------------------------------------------------
`default_nettype none

module b64enc_front
    import b64enc_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_in_beat  i_in_data,
    input  wire t_q_status i_q_status,
    output logic           o_push,
    output t_group         o_push_data
);

    logic [1:0] r_cnt, n_cnt;
    logic [7:0] r_byte0, r_byte1;
    logic       w_accept;
    logic       w_full_grp;

    assign o_in_ready = !i_q_status.full;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_full_grp = r_cnt[1];
    assign o_push     = w_accept && (w_full_grp || i_in_data.end_of_message);

    always_comb begin
        o_push_data = '0;
        n_cnt       = r_cnt;
        if (w_full_grp) begin
            o_push_data = '{r_byte0, r_byte1, i_in_data.data_byte, NVALID_THREE,
                            i_in_data.end_of_message};
        end else if (r_cnt[0]) begin
            o_push_data = '{r_byte0, i_in_data.data_byte, 8'h00, NVALID_TWO, 1'b1};
        end else begin
            o_push_data = '{i_in_data.data_byte, 8'h00, 8'h00, NVALID_ONE, 1'b1};
        end
        if (w_accept) begin
            if (o_push) begin
                n_cnt = 2'd0;
            end else begin
                n_cnt = r_cnt + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && !o_push) begin
            if (r_cnt[0]) begin
                r_byte1 <= i_in_data.data_byte;
            end else begin
                r_byte0 <= i_in_data.data_byte;
            end
        end
    end

endmodule

`default_nettype wire

// ===== hdl/b64enc_queue.sv =====
// ----------------------------------------------------------------------------
// b64enc_queue
// Short group queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module b64enc_queue
    import b64enc_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  wire t_group i_push_data,
    input  wire logic   i_pop,
    output t_group      o_pop_data,
    output t_q_status   o_status
);

    t_group              r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wp, n_wp;
    logic [QUEUE_AW-1:0] r_rp, n_rp;
    logic [QUEUE_CW-1:0] r_count, n_count;
    logic                w_pop;

    assign w_pop                = i_pop && (r_count != '0);
    assign o_pop_data           = r_mem[r_rp];
    assign o_status.full        = (r_count == QUEUE_CW'(QUEUE_DEPTH));
    assign o_status.not_empty   = (r_count != '0);
    assign o_status.count       = r_count;

    always_comb begin
        n_wp    = r_wp;
        n_rp    = r_rp;
        n_count = r_count;
        if (i_push) begin
            n_wp = (r_wp == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : r_wp + QUEUE_AW'(1);
        end
        if (w_pop) begin
            n_rp = (r_rp == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : r_rp + QUEUE_AW'(1);
        end
        unique case ({i_push, w_pop})
            2'b10:   n_count = r_count + QUEUE_CW'(1);
            2'b01:   n_count = r_count - QUEUE_CW'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_push_data;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/b64enc_back.sv =====
// ----------------------------------------------------------------------------
// b64enc_back
// Takes groups from the queue and sends them out one character per beat.
// ----------------------------------------------------------------------------
`default_nettype none

module b64enc_back
    import b64enc_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_q_status i_q_status,
    input  wire t_group    i_q_data,
    output logic           o_pop,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_out_beat      o_out_data
);

    t_group     r_grp;
    logic       r_busy, n_busy;
    logic [1:0] r_idx, n_idx;
    logic       r_out_valid, n_out_valid;
    t_out_beat  r_out;
    t_out_beat  w_beat;
    logic       w_adv;
    logic       w_at_last;
    logic [5:0] w_six;

    assign w_adv       = !r_out_valid || i_out_ready;
    assign w_at_last   = (r_idx == CHAR_IDX_LAST);
    assign o_pop       = w_adv && (!r_busy || w_at_last) && i_q_status.not_empty;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        unique case (r_idx)
            2'd0:    w_six = r_grp.byte_a[7:2];
            2'd1:    w_six = {r_grp.byte_a[1:0], r_grp.byte_b[7:4]};
            2'd2:    w_six = {r_grp.byte_b[3:0], r_grp.byte_c[7:6]};
            default: w_six = r_grp.byte_c[5:0];
        endcase
        w_beat.out_char     = (r_idx <= r_grp.nvalid) ? b64_char(w_six) : CHAR_PAD;
        w_beat.group_last   = w_at_last;
        w_beat.message_done = w_at_last && r_grp.done;
    end

    always_comb begin
        n_busy      = r_busy;
        n_idx       = r_idx;
        n_out_valid = r_out_valid;
        if (w_adv) begin
            n_out_valid = r_busy;
            if (r_busy) begin
                n_idx = r_idx + 2'd1;
            end
            n_busy = (r_busy && !w_at_last) || o_pop;
            if (o_pop) begin
                n_idx = 2'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_idx       <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_grp <= i_q_data;
        end
        if (w_adv && r_busy) begin
            r_out <= w_beat;
        end
    end

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the streaming base64 encoder: byte beats go in under
// random idling and back-pressure, each accepted byte updates a model of the
// held bytes, and every character beat is compared with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top
    import b64enc_pkg::*;
;

    class char_predictor;
        logic [1:0] held_count;
        logic [7:0] held_bytes [2];
        t_out_beat  expected_chars [$];
        int         mismatches;
        string      alphabet;

        function new();
            held_count    = 2'd0;
            held_bytes[0] = 8'h00;
            held_bytes[1] = 8'h00;
            mismatches    = 0;
            alphabet      = {"ABCDEFGHIJKLMNOPQRSTUVWXYZ",
                             "abcdefghijklmnopqrstuvwxyz",
                             "0123456789+/"};
        endfunction

        function void push_group(logic [7:0] a, logic [7:0] b, logic [7:0] c,
                                 int real_bytes, logic done);
            logic [5:0] six [4];
            t_out_beat  beat;
            six[0] = a[7:2];
            six[1] = {a[1:0], b[7:4]};
            six[2] = {b[3:0], c[7:6]};
            six[3] = c[5:0];
            for (int k = 0; k < 4; k++) begin
                if (k <= real_bytes) begin
                    beat.out_char = 8'(alphabet[int'(six[k])]);
                end else begin
                    beat.out_char = CHAR_PAD;
                end
                beat.group_last   = (k == 3);
                beat.message_done = (k == 3) ? done : 1'b0;
                expected_chars.push_back(beat);
            end
        endfunction

        function void note_byte(t_in_beat b);
            if (held_count >= 2'd2) begin
                push_group(held_bytes[0], held_bytes[1], b.data_byte, 3, b.end_of_message);
                held_count = 2'd0;
            end else if (b.end_of_message) begin
                if (held_count == 2'd0) begin
                    push_group(b.data_byte, 8'h00, 8'h00, 1, 1'b1);
                end else begin
                    push_group(held_bytes[0], b.data_byte, 8'h00, 2, 1'b1);
                end
                held_count = 2'd0;
            end else begin
                held_bytes[held_count[0]] = b.data_byte;
                held_count = held_count + 2'd1;
            end
        endfunction

        function void report(string what, t_out_beat exp_beat, t_out_beat got);
            mismatches++;
            if (mismatches <= 10) begin
                $display("%s: expected char %h last %b done %b, got char %h last %b done %b",
                         what, exp_beat.out_char, exp_beat.group_last, exp_beat.message_done,
                         got.out_char, got.group_last, got.message_done);
            end
        endfunction

        function void check_char(t_out_beat got);
            t_out_beat exp_beat;
            if (expected_chars.size() == 0) begin
                exp_beat = '0;
                report("unexpected beat", exp_beat, got);
            end else begin
                exp_beat = expected_chars.pop_front();
                if (got.out_char !== exp_beat.out_char
                        || got.group_last !== exp_beat.group_last
                        || got.message_done !== exp_beat.message_done) begin
                    report("mismatch", exp_beat, got);
                end
            end
        endfunction

        function int outstanding();
            return expected_chars.size();
        endfunction
    endclass

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_beat  i_in_data;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_beat o_out_data;

    char_predictor sb;
    int            send_idle_pct;
    int            recv_idle_pct;
    bit            long_hold_go;

    base64_stream_encoder_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            sb.check_char(o_out_data);
        end
    end

    initial begin
        bit hold_done;
        hold_done   = 1'b0;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (long_hold_go && !hold_done) begin
                i_out_ready <= 1'b0;
                repeat (60) @(negedge i_clk);
                hold_done = 1'b1;
            end
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic send_byte(input t_in_beat beat);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= beat;
        forever begin
            @(posedge i_clk);
            if (o_in_ready) break;
        end
        sb.note_byte(beat);
        @(negedge i_clk);
    endtask

    task automatic send_directed(input logic [63:0] bytes, input int len);
        t_in_beat beat;
        for (int i = 0; i < len; i++) begin
            beat.data_byte      = bytes[8*(len-i)-1 -: 8];
            beat.end_of_message = (i == len - 1);
            send_byte(beat);
        end
    endtask

    task automatic send_random_message(input int len);
        t_in_beat beat;
        for (int i = 0; i < len; i++) begin
            beat.data_byte      = 8'($urandom_range(255));
            beat.end_of_message = (i == len - 1);
            send_byte(beat);
        end
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (sb.outstanding() != 0) @(negedge i_clk);
    endtask

    task automatic run_random_phase(input int n_bytes);
        int sent;
        int len;
        sent = 0;
        while (sent < n_bytes) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(24, 12) : $urandom_range(7, 1);
            send_random_message(len);
            sent += len;
        end
    endtask

    initial begin
        sb            = new();
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_in_data     = '0;
        long_hold_go  = 1'b0;
        send_idle_pct = 20;
        recv_idle_pct = 53;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_directed(64'h00, 1);
        send_directed(64'hFF, 1);
        send_directed(64'hFFFF, 2);
        send_directed(64'h0000, 2);
        send_directed(64'h4D616E, 3);
        send_directed(64'hFBFFBF, 3);
        send_directed(64'h000000FF, 4);
        send_directed(64'hFFFFFF0000, 5);
        wait_drained();

        long_hold_go = 1'b1;
        send_random_message(30);
        run_random_phase(35);
        wait_drained();

        send_idle_pct = 53;
        recv_idle_pct = 20;
        run_random_phase(35);
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random_phase(35);
        wait_drained();

        repeat (10) @(negedge i_clk);
        if (sb.mismatches == 0 && sb.outstanding() == 0) begin
            $display("base64_stream_encoder_core test passed");
        end else begin
            $display("base64_stream_encoder_core test failed");
        end
        $finish;
    end

    initial begin
        #200000;
        $display("base64_stream_encoder_core test failed");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/b64enc_pkg.sv
hdl/b64enc_front.sv
hdl/b64enc_queue.sv
hdl/b64enc_back.sv
hdl/base64_stream_encoder_core.sv
bench/tb_top.sv
